// ----- sv/xor_fec_dedup_receiver_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the XOR FEC receiver
// Implication checks on the receiver clock, held off while reset is active.
// ---------------------------------------------------------------------------
`ifndef XOR_FEC_DEDUP_RECEIVER_UNIT_MACROS_SVH
`define XOR_FEC_DEDUP_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication.
`define XFDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xfdr: assertion failed");

// Next-cycle implication.
`define XFDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xfdr: assertion failed");

`endif

// ----- sv/xfdr_pkg.sv -----
// ---------------------------------------------------------------------------
// xfdr_pkg
// Packet kinds, reset values and sequencer states of the XOR FEC receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package xfdr_pkg;

  localparam logic [1:0]  KIND_DATA   = 2'd0;
  localparam logic [1:0]  KIND_PARITY = 2'd1;
  localparam logic [10:0] FC_RESET    = 11'd1024;

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_LOOK  = 15'h0004,
    S_ACT   = 15'h0008,
    S_MOD1  = 15'h0010,
    S_MOD2  = 15'h0020,
    S_RCHK  = 15'h0040,
    S_RPV   = 15'h0080,
    S_SCRD  = 15'h0100,
    S_SCCK  = 15'h0200,
    S_RBPRD = 15'h0400,
    S_RBPX  = 15'h0800,
    S_RBMRD = 15'h1000,
    S_RBMX  = 15'h2000,
    S_RBWR  = 15'h4000
  } state_e;

endpackage

// ----- sv/xor_fec_dedup_receiver_unit.sv -----
// ---------------------------------------------------------------------------
// XOR FEC receiver with duplicate suppression
// Stores and forwards data frames, keeps parity groups and rebuilds a
// single missing group member by XOR.
// ---------------------------------------------------------------------------
// Usage: drive one payload word with start high while busy is low; that
// edge is the input transfer. Each result word appears for exactly one cycle
// with out_valid_o high; the receiver cannot stall, so the block never waits.
// A data word passes S_LOOK and S_ACT after its transfer and is then
// registered onto the result ports; busy goes low as it appears, so the
// next word can be taken while that result is shown. Ignored words pass
// the same states. The last word of a packet may start a recovery:
// a data packet first finds its group base with a shared shift-subtract
// remainder unit (two passes), then any packet checks parity (S_RCHK,
// S_RPV), walks the group's valid bits, reading only members in range,
// and, with exactly one member missing, rebuilds it word by word through
// the single read port of the frame store. frame_count is written over
// the cfg channel, which is always ready. After reset the valid memories
// are swept clear, one slot a cycle, while busy stays high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xor_fec_dedup_receiver_unit_macros.svh"

module xor_fec_dedup_receiver_unit
  import xfdr_pkg::*;
#(
  parameter int FRAME_SLOTS   = 1024,
  parameter int PAYLOAD_BYTES = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  packet_kind_i,
  input  logic [31:0] seq_or_base_i,
  input  logic [7:0]  group_size_i,
  input  logic [7:0]  group_stride_i,
  input  logic [4:0]  word_index_i,
  input  logic [63:0] payload_word_i,
  input  logic        last_word_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,
  output logic        out_valid_o,
  output logic [9:0]  out_seq_o,
  output logic [4:0]  out_word_index_o,
  output logic [63:0] out_word_o,
  output logic        out_recovered_o,
  output logic        out_last_o
);

  localparam int WORDS = (PAYLOAD_BYTES + 7) / 8;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SW    = $clog2(FRAME_SLOTS);
  localparam int DEPTH = FRAME_SLOTS * WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (SW + 1 > 11) ? SW + 1 : 11;
  localparam int DW    = (SW > 16) ? SW : 16;
  localparam int CW    = $clog2(DW + 1);

  // Storage: frame and parity payload words, and a frame and a parity valid bit per slot.
  logic [63:0] frame_mem  [DEPTH];
  logic [63:0] parity_mem [DEPTH];
  logic        fv_mem     [FRAME_SLOTS];
  logic        pv_mem     [FRAME_SLOTS];

  state_e state_q, state_d;

  // Captured item.
  logic [1:0]  kind_q;
  logic [31:0] seq_q;
  logic [7:0]  size_q, stride_q;
  logic [4:0]  wi_q;
  logic [63:0] word_q;
  logic        last_q;

  logic [10:0] fc_q;
  logic [7:0]  ls_q, ls_d, lsp_q, lsp_d;
  logic [SW-1:0] clr_q, clr_d;

  // Remainder unit and recovery walk.
  logic [DW-1:0] rem_q, rem_d, dvd_q, dvd_d, r1_q, r1_d;
  logic [15:0]   div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   base_q, base_d;
  logic [DW:0]   s_q, s_d;
  logic [7:0]    m_q, m_d;
  logic          miss_seen_q, miss_seen_d;
  logic [SW-1:0] miss_q, miss_d;
  logic [WW-1:0] w_q, w_d;
  logic [63:0]   acc_q, acc_d;
  logic          take_q, take_d;

  // Memory ports.
  logic          fv_we, fv_wdata, pv_we, pv_wdata, fv_rd_q, pv_rd_q;
  logic [SW-1:0] fv_waddr, pv_waddr, v_raddr;
  logic          fm_we, pm_we;
  logic [AW-1:0] fm_waddr, pm_waddr, fm_raddr, pm_raddr;
  logic [63:0]   fm_wdata, fm_rd_q, pm_rd_q;

  // Result register.
  logic        ov_q, ov_d, orec_q, orec_d, olast_q, olast_d;
  logic [9:0]  oseq_q, oseq_d;
  logic [4:0]  owi_q, owi_d;
  logic [63:0] oword_q, oword_d;

  logic [LW-1:0] lim_w;
  logic [31:0]   lim32;
  logic          seq_in, wi_in;
  logic [SW-1:0] seq_idx;
  logic [DW:0]   step_t, step_r;
  logic          step_ge;
  logic [SW-1:0] s_idx;
  logic          s_in;

  assign lim_w   = (LW'(fc_q) < LW'(FRAME_SLOTS)) ? LW'(fc_q) : LW'(FRAME_SLOTS);
  assign lim32   = 32'(lim_w);
  assign seq_in  = seq_q < lim32;
  assign wi_in   = 32'(wi_q) < WORDS;
  assign seq_idx = seq_q[SW-1:0];
  assign s_in    = 32'(s_q) < lim32;
  assign s_idx   = s_q[SW-1:0];

  // One shift-subtract step of the remainder unit.
  assign step_t  = {rem_q, dvd_q[DW-1]};
  assign step_ge = step_t >= (DW + 1)'(div_q);
  assign step_r  = step_ge ? step_t - (DW + 1)'(div_q) : step_t;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    ls_d = ls_q;  lsp_d = lsp_q;  clr_d = clr_q;
    rem_d = rem_q;  dvd_d = dvd_q;  r1_d = r1_q;  div_d = div_q;  cnt_d = cnt_q;
    base_d = base_q;  s_d = s_q;  m_d = m_q;
    miss_seen_d = miss_seen_q;  miss_d = miss_q;
    w_d = w_q;  acc_d = acc_q;  take_d = take_q;
    fv_we = 1'b0;  fv_wdata = 1'b0;  fv_waddr = seq_idx;
    pv_we = 1'b0;  pv_wdata = 1'b0;  pv_waddr = seq_idx;
    v_raddr = seq_idx;
    fm_we = 1'b0;  fm_waddr = AW'(seq_idx) * AW'(WORDS) + AW'(wi_q);  fm_wdata = word_q;
    pm_we = 1'b0;  pm_waddr = fm_waddr;
    fm_raddr = AW'(s_idx) * AW'(WORDS) + AW'(w_q);
    pm_raddr = AW'(base_q[SW-1:0]) * AW'(WORDS) + AW'(w_q);
    ov_d = 1'b0;  oseq_d = oseq_q;  owi_d = owi_q;  oword_d = oword_q;
    orec_d = orec_q;  olast_d = olast_q;

    case (state_q)
      S_CLEAR: begin
        fv_we = 1'b1;  fv_waddr = clr_q;
        pv_we = 1'b1;  pv_waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == SW'(FRAME_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_ACT;
      end
      S_ACT: begin
        state_d = S_IDLE;
        if (kind_q == KIND_DATA) begin
          if (seq_in && !fv_rd_q) begin
            if (wi_in) begin
              fm_we   = 1'b1;
              ov_d    = 1'b1;
              oseq_d  = 10'(seq_q);
              owi_d   = wi_q;
              oword_d = word_q;
              orec_d  = 1'b0;
              olast_d = last_q;
            end
            if (last_q) begin
              fv_we = 1'b1;  fv_wdata = 1'b1;
            end
          end
          if (last_q && seq_in && ls_q != 8'd0 && lsp_q != 8'd0) begin
            rem_d   = '0;
            dvd_d   = DW'(seq_idx);
            div_d   = 16'(ls_q * lsp_q);
            cnt_d   = '0;
            state_d = S_MOD1;
          end
        end else if (kind_q == KIND_PARITY && size_q != 8'd0 && stride_q != 8'd0) begin
          if (seq_in && !pv_rd_q && wi_in) begin
            pm_we = 1'b1;
          end
          if (last_q) begin
            ls_d  = size_q;
            lsp_d = stride_q;
            if (seq_in) begin
              pv_we = 1'b1;  pv_wdata = 1'b1;
            end
            base_d  = seq_q;
            state_d = S_RCHK;
          end
        end
      end
      S_MOD1: begin
        rem_d = step_r[DW-1:0];
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          r1_d    = step_r[DW-1:0];
          rem_d   = '0;
          dvd_d   = step_r[DW-1:0];
          div_d   = {8'd0, lsp_q};
          cnt_d   = '0;
          state_d = S_MOD2;
        end
      end
      S_MOD2: begin
        rem_d = step_r[DW-1:0];
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          base_d  = seq_q - 32'(r1_q) + 32'(step_r[DW-1:0]);
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        v_raddr = base_q[SW-1:0];
        state_d = (base_q < lim32) ? S_RPV : S_IDLE;
      end
      S_RPV: begin
        m_d         = '0;
        s_d         = (DW + 1)'(base_q[SW-1:0]);
        miss_seen_d = 1'b0;
        state_d     = pv_rd_q ? S_SCRD : S_IDLE;
      end
      S_SCRD: begin
        v_raddr = s_idx;
        if (m_q == ls_q) begin
          w_d     = '0;
          state_d = miss_seen_q ? S_RBPRD : S_IDLE;
        end else if (!s_in) begin
          m_d = m_q + 1'b1;
          s_d = s_q + (DW + 1)'(lsp_q);
        end else begin
          state_d = S_SCCK;
        end
      end
      S_SCCK: begin
        m_d     = m_q + 1'b1;
        s_d     = s_q + (DW + 1)'(lsp_q);
        state_d = S_SCRD;
        if (!fv_rd_q) begin
          if (miss_seen_q) begin
            state_d = S_IDLE;
          end
          miss_seen_d = 1'b1;
          miss_d      = s_idx;
        end
      end
      S_RBPRD: begin
        state_d = S_RBPX;
      end
      S_RBPX: begin
        acc_d   = pm_rd_q;
        m_d     = '0;
        s_d     = (DW + 1)'(base_q[SW-1:0]);
        state_d = S_RBMRD;
      end
      S_RBMRD: begin
        if (m_q == ls_q) begin
          state_d = S_RBWR;
        end else begin
          take_d  = s_in && (s_idx != miss_q);
          state_d = S_RBMX;
        end
      end
      S_RBMX: begin
        if (take_q) begin
          acc_d = acc_q ^ fm_rd_q;
        end
        m_d     = m_q + 1'b1;
        s_d     = s_q + (DW + 1)'(lsp_q);
        state_d = S_RBMRD;
      end
      S_RBWR: begin
        fm_we    = 1'b1;
        fm_waddr = AW'(miss_q) * AW'(WORDS) + AW'(w_q);
        fm_wdata = acc_q;
        ov_d     = 1'b1;
        oseq_d   = 10'(miss_q);
        owi_d    = 5'(w_q);
        oword_d  = acc_q;
        orec_d   = 1'b1;
        olast_d  = (w_q == WW'(WORDS - 1));
        w_d      = w_q + 1'b1;
        state_d  = S_RBPRD;
        if (w_q == WW'(WORDS - 1)) begin
          fv_we    = 1'b1;
          fv_waddr = miss_q;
          fv_wdata = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fc_q        <= FC_RESET;
      ls_q        <= '0;
      lsp_q       <= '0;
      clr_q       <= '0;
      cnt_q       <= '0;
      m_q         <= '0;
      w_q         <= '0;
      miss_seen_q <= 1'b0;
      take_q      <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      ls_q        <= ls_d;
      lsp_q       <= lsp_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      m_q         <= m_d;
      w_q         <= w_d;
      miss_seen_q <= miss_seen_d;
      take_q      <= take_d;
      ov_q        <= ov_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q   <= packet_kind_i;
      seq_q    <= seq_or_base_i;
      size_q   <= group_size_i;
      stride_q <= group_stride_i;
      wi_q     <= word_index_i;
      word_q   <= payload_word_i;
      last_q   <= last_word_i;
    end
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    r1_q    <= r1_d;
    div_q   <= div_d;
    base_q  <= base_d;
    s_q     <= s_d;
    miss_q  <= miss_d;
    acc_q   <= acc_d;
    oseq_q  <= oseq_d;
    owi_q   <= owi_d;
    oword_q <= oword_d;
    orec_q  <= orec_d;
    olast_q <= olast_d;
  end

  // Memories, read data registered.
  always_ff @(posedge clk_i) begin
    if (fv_we) begin
      fv_mem[fv_waddr] <= fv_wdata;
    end
    if (pv_we) begin
      pv_mem[pv_waddr] <= pv_wdata;
    end
    fv_rd_q <= fv_mem[v_raddr];
    pv_rd_q <= pv_mem[v_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      frame_mem[fm_waddr] <= fm_wdata;
    end
    if (pm_we) begin
      parity_mem[pm_waddr] <= word_q;
    end
    fm_rd_q <= frame_mem[fm_raddr];
    pm_rd_q <= parity_mem[pm_raddr];
  end

  assign out_valid_o      = ov_q;
  assign out_seq_o        = oseq_q;
  assign out_word_index_o = owi_q;
  assign out_word_o       = oword_q;
  assign out_recovered_o  = orec_q;
  assign out_last_o       = olast_q;

  // An accepted word always occupies the sequencer.
  `XFDR_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // Received words leave only from the action step.
  `XFDR_ASSERT_NOW(a_fwd_src, clk_i, rst_ni, out_valid_o && !out_recovered_o,
                   $past(state_q) == S_ACT)
  // A rebuilt frame ends exactly on its final word.
  `XFDR_ASSERT_NOW(a_rec_last, clk_i, rst_ni, out_valid_o && out_recovered_o && out_last_o,
                   out_word_index_o == 5'(WORDS - 1))

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// XOR FEC receiver testbench
// Drives well-formed parity groups with one member held back, duplicates and
// ignored packets through the command port, predicts every forwarded and
// rebuilt word, and checks each output strobe against that prediction.
// ---------------------------------------------------------------------------

module tb_top;
  import xfdr_pkg::*;

  localparam int SLOTS       = 1024;
  localparam int WORDS       = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 2000;
  localparam logic [1:0] KIND_SHORT = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [7:0]  size;
    logic [7:0]  stride;
    logic [4:0]  wi;
    logic [63:0] word;
    logic        last;
  } pkt_word_t;

  typedef struct packed {
    logic [9:0]  seq;
    logic [4:0]  wi;
    logic [63:0] word;
    logic        rec;
    logic        last;
  } out_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  packet_kind_i = '0;
  logic [31:0] seq_or_base_i = '0;
  logic [7:0]  group_size_i = '0;
  logic [7:0]  group_stride_i = '0;
  logic [4:0]  word_index_i = '0;
  logic [63:0] payload_word_i = '0;
  logic        last_word_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic [9:0]  out_seq_o;
  logic [4:0]  out_word_index_o;
  logic [63:0] out_word_o;
  logic        out_recovered_o;
  logic        out_last_o;

  xor_fec_dedup_receiver_unit DUT (
    .clk_i, .rst_ni, .start, .busy,
    .packet_kind_i, .seq_or_base_i, .group_size_i, .group_stride_i,
    .word_index_i, .payload_word_i, .last_word_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .out_valid_o, .out_seq_o, .out_word_index_o, .out_word_o,
    .out_recovered_o, .out_last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the receiver state. Store words that were never written
  // read back as zero, but the stimulus never makes the block read them.
  logic [63:0]      frame_mem[int];
  logic [63:0]      parity_mem[int];
  logic [SLOTS-1:0] frame_held = '0;
  logic [SLOTS-1:0] parity_held = '0;
  int unsigned      grp_size = 0;
  int unsigned      grp_stride = 0;
  int unsigned      frame_count = 1024;

  pkt_word_t pending_q[$];
  out_word_t expected_q[$];
  int        fail_count = 0;
  bit        calm = 0;

  function automatic int unsigned slot_limit();
    return (frame_count < SLOTS) ? frame_count : SLOTS;
  endfunction

  function automatic void push_word(int unsigned seq, int unsigned wi, logic [63:0] w,
                                    logic rec, logic last);
    out_word_t o;
    o.seq  = seq[9:0];
    o.wi   = wi[4:0];
    o.word = w;
    o.rec  = rec;
    o.last = last;
    expected_q.push_back(o);
  endfunction

  // Rebuilds the single missing member of the group at base, if there is one.
  function automatic void try_rebuild(int unsigned base);
    int unsigned lim, s, miss, nmiss;
    logic [63:0] acc;
    lim = slot_limit();
    miss = 0;
    nmiss = 0;
    if (base >= lim || !parity_held[base]) return;
    if (grp_size == 0 || grp_stride == 0) return;
    for (int unsigned m = 0; m < grp_size; m++) begin
      s = base + m * grp_stride;
      if (s < lim && !frame_held[s]) begin
        nmiss++;
        miss = s;
        if (nmiss > 1) return;
      end
    end
    if (nmiss != 1) return;
    for (int unsigned w = 0; w < WORDS; w++) begin
      acc = parity_mem.exists(base * WORDS + w) ? parity_mem[base * WORDS + w] : '0;
      for (int unsigned m = 0; m < grp_size; m++) begin
        s = base + m * grp_stride;
        if (s < lim && s != miss && frame_mem.exists(s * WORDS + w))
          acc ^= frame_mem[s * WORDS + w];
      end
      frame_mem[miss * WORDS + w] = acc;
      push_word(miss, w, acc, 1'b1, (w + 1 == WORDS));
    end
    frame_held[miss] = 1'b1;
  endfunction

  // Applies one accepted payload word to the shadow state and queues the
  // output words it causes.
  function automatic void predict_receive(pkt_word_t p);
    int unsigned lim, seq, len, base;
    lim = slot_limit();
    seq = p.seq;
    if (p.kind == KIND_DATA) begin
      if (seq < lim && !frame_held[seq]) begin
        if (p.wi < WORDS) begin
          frame_mem[seq * WORDS + p.wi] = p.word;
          push_word(seq, p.wi, p.word, 1'b0, p.last);
        end
        if (p.last) frame_held[seq] = 1'b1;
      end
      if (p.last && seq < lim && grp_size != 0 && grp_stride != 0) begin
        len = grp_size * grp_stride;
        base = (seq / len) * len + (seq % len) % grp_stride;
        try_rebuild(base);
      end
    end else if (p.kind == KIND_PARITY) begin
      if (p.size == 0 || p.stride == 0) return;
      if (seq < lim && !parity_held[seq] && p.wi < WORDS)
        parity_mem[seq * WORDS + p.wi] = p.word;
      if (p.last) begin
        grp_size = p.size;
        grp_stride = p.stride;
        if (seq < lim) parity_held[seq] = 1'b1;
        try_rebuild(seq);
      end
    end
  endfunction

  // Driver: a word stays on the port until the edge that transfers it, then
  // the next one from the queue follows at once unless an idle burst starts.
  int idle_left = 0;
  always @(posedge clk_i) begin
    automatic bit hold;
    hold = start && busy;
    if (start && !busy) predict_receive(pending_q.pop_front());
    if (!hold) begin
      if (idle_left == 0 && !calm && $urandom_range(0, 11) == 0)
        idle_left = $urandom_range(1, 10);
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        start          <= 1'b1;
        packet_kind_i  <= pending_q[0].kind;
        seq_or_base_i  <= pending_q[0].seq;
        group_size_i   <= pending_q[0].size;
        group_stride_i <= pending_q[0].stride;
        word_index_i   <= pending_q[0].wi;
        payload_word_i <= pending_q[0].word;
        last_word_i    <= pending_q[0].last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Monitor: every strobed output word is checked against the oldest
  // prediction, field by field.
  always @(posedge clk_i) begin
    automatic out_word_t e;
    if (rst_ni && out_valid_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word seq %0d wi %0d", out_seq_o,
                                  out_word_index_o));
      end else begin
        e = expected_q.pop_front();
        if (out_seq_o !== e.seq)
          report_mismatch($sformatf("seq %0d, want %0d", out_seq_o, e.seq));
        if (out_word_index_o !== e.wi)
          report_mismatch($sformatf("word index %0d, want %0d", out_word_index_o, e.wi));
        if (out_word_o !== e.word)
          report_mismatch($sformatf("word %h, want %h", out_word_o, e.word));
        if (out_recovered_o !== e.rec)
          report_mismatch($sformatf("recovered %b, want %b", out_recovered_o, e.rec));
        if (out_last_o !== e.last)
          report_mismatch($sformatf("last %b, want %b", out_last_o, e.last));
      end
    end
  end

  int cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_word(input logic [1:0] kind, input logic [31:0] seq,
                          input logic [7:0] size, input logic [7:0] stride,
                          input logic [4:0] wi, input logic [63:0] w, input logic last);
    pkt_word_t p;
    p.kind = kind;
    p.seq = seq;
    p.size = size;
    p.stride = stride;
    p.wi = wi;
    p.word = w;
    p.last = last;
    pending_q.push_back(p);
  endtask

  // A complete packet: all payload words in order. Sometimes a stray word
  // beyond the payload is slipped in, and sometimes the end mark rides on
  // such a word after the full payload.
  task automatic add_packet(input logic [1:0] kind, input int unsigned seq,
                            input logic [7:0] size, input logic [7:0] stride);
    bit late_mark;
    late_mark = ($urandom_range(0, 5) == 0);
    for (int w = 0; w < WORDS; w++) begin
      if ($urandom_range(0, 15) == 0)
        add_word(kind, seq, size, stride, $urandom_range(WORDS, 31), rand_word(), 1'b0);
      add_word(kind, seq, size, stride, w, rand_word(), (w == WORDS - 1) && !late_mark);
    end
    if (late_mark)
      add_word(kind, seq, size, stride, $urandom_range(WORDS, 31), rand_word(), 1'b1);
  endtask

  // Words that the block must ignore: short kinds, data beyond the slot
  // limit, parity without geometry, and parity for a base beyond the limit.
  task automatic add_noise(input int unsigned lim);
    logic [31:0] far;
    far = lim + $urandom_range(0, 32'h7fff_ffff);
    case ($urandom_range(0, 4))
      0: add_word(KIND_SHORT, $urandom, $urandom, $urandom, $urandom, rand_word(), $urandom);
      1: add_word(KIND_SPARE, $urandom, $urandom, $urandom, $urandom, rand_word(), $urandom);
      2: add_word(KIND_DATA, far, $urandom, $urandom, $urandom, rand_word(), $urandom);
      3: add_word(KIND_PARITY, $urandom, 8'd0, $urandom, $urandom, rand_word(), $urandom);
      default: add_word(KIND_PARITY, far, $urandom_range(1, 255), $urandom_range(1, 255),
                        $urandom, rand_word(), 1'b0);
    endcase
  endtask

  // One parity group: parity first, then every member but one in random
  // order, with an occasional duplicate. The last member triggers a rebuild.
  task automatic add_group(input int unsigned lim);
    int unsigned k, sp, len, base, hole;
    int unsigned order[$];
    k = $urandom_range(2, 3);
    sp = $urandom_range(1, 3);
    len = k * sp;
    base = ($urandom_range(0, (lim > len) ? lim / len : 1)) * len + $urandom_range(0, sp - 1);
    hole = $urandom_range(0, k - 1);
    add_packet(KIND_PARITY, base, k, sp);
    for (int unsigned m = 0; m < k; m++)
      if (m != hole) order.push_back(m);
    order.shuffle();
    foreach (order[i]) begin
      add_packet(KIND_DATA, base + order[i] * sp, 8'd0, 8'd0);
      if ($urandom_range(0, 3) == 0)
        add_packet(KIND_DATA, base + order[$urandom_range(0, i)] * sp, 8'd0, 8'd0);
    end
  endtask

  // Waits until every word is sent and every prediction has arrived, then
  // leaves room for a walk that produces nothing before the block is idle.
  task automatic drain();
    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_frame_count(input logic [10:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    frame_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [10:0] setting, input int groups);
    write_frame_count(setting);
    for (int g = 0; g < groups; g++) begin
      repeat ($urandom_range(1, 4)) add_noise(slot_limit());
      add_group(slot_limit());
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The valid memories are swept after reset while busy is high.
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // Directed: ignored kinds, the widest sequence number, parity without
    // size or stride, and parity that teaches the widest geometry.
    add_word(KIND_SHORT, '1, '1, '1, 5'd31, '1, 1'b1);
    add_word(KIND_SPARE, '0, '0, '0, 5'd0, '0, 1'b1);
    add_word(KIND_DATA, 32'hffff_ffff, '0, '0, 5'd19, '1, 1'b1);
    add_word(KIND_PARITY, 32'd5, 8'd0, 8'd3, 5'd0, '1, 1'b1);
    add_word(KIND_PARITY, 32'd5, 8'd3, 8'd0, 5'd0, '1, 1'b1);
    add_word(KIND_PARITY, 32'hffff_ffff, 8'd255, 8'd255, 5'd19, '1, 1'b1);
    add_packet(KIND_DATA, 0, 8'd0, 8'd0);
    add_packet(KIND_DATA, SLOTS - 1, 8'd0, 8'd0);
    drain();

    run_phase(11'd2047, 1);
    run_phase(11'd37, 1);
    calm = 1;
    run_phase(FC_RESET, 1);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
